### design/mlqs_pkg.sv
// ============================================================================
// mlqs_pkg: shared types for the multilevel queue slot scheduler
// request and result structs, operation and status codes, sequencer states
// ============================================================================
package mlqs_pkg;

    typedef enum logic [1:0] {
        MODE_ENQUEUE = 2'd0,
        MODE_REQUEST = 2'd1,
        MODE_CHARGE  = 2'd2,
        MODE_NOP     = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_GRANT    = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_SCAN,
        S_FETCH,
        S_GRANT
    } state_t;

    typedef struct packed {
        mode_t       mode;
        logic [7:0]  task_id;
        logic [2:0]  level;
        logic [3:0]  used_slots;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  out_task;
        logic [2:0]  out_level;
        logic [3:0]  out_budget;
    } rsp_t;

endpackage

### design/multilevel_queue_slot_scheduler.sv
// ============================================================================
// multilevel_queue_slot_scheduler
// multilevel ready-queue scheduler with a per-level slot budget
// ============================================================================
// A request is taken when start is high and busy is low; the block then stays
// busy until its single result goes out on rsp for one cycle, flagged by
// rsp_valid, and busy drops in that same cycle so the next request can be taken
// at the edge that ends it. The result cannot be held off. An enqueue or a
// charge reads the level's count, head and budget memories in S_READ and
// updates them in S_EXEC, which also registers the result. A request for
// the next task walks the ready flags one level per cycle, then reads the
// task memory in S_FETCH and updates the level in S_GRANT. When no level is
// ready the walk covers every level, refills the budgets and walks again,
// and the grant may then come from the second walk. There is no clearing
// pass: budgets and counts use per-level flags.
// ============================================================================
module multilevel_queue_slot_scheduler #(
    parameter int LEVELS      = 8,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  mlqs_pkg::req_t  req,
    output logic            rsp_valid,
    output mlqs_pkg::rsp_t  rsp
);

    // widths derived from the configuration
    localparam int LW   = $clog2(LEVELS);
    localparam int BW   = $clog2(LEVELS + 1);
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
    localparam int HW   = $clog2(QUEUE_DEPTH);
    localparam int TAW  = $clog2(LEVELS * QUEUE_DEPTH);
    localparam int SW   = (BW > 4) ? BW : 4;

    // sequencer and latched request
    mlqs_pkg::state_t state_reg, state_next;
    mlqs_pkg::req_t   req_reg;
    logic [LW-1:0]    scan_reg, scan_next;
    logic             pass_reg, pass_next;

    // per-level flags: queue not empty, budget not zero, budget written
    logic [LEVELS-1:0] nonempty_reg, nonempty_next;
    logic [LEVELS-1:0] bnz_reg, bnz_next;
    logic [LEVELS-1:0] bval_reg, bval_next;
    logic [LEVELS-1:0] ready_vec;

    // result register
    mlqs_pkg::rsp_t   rsp_reg, rsp_next;
    logic             rsp_valid_reg, rsp_valid_next;

    // memories with registered read data
    logic [CNTW-1:0]  count_mem [LEVELS];
    logic [HW-1:0]    head_mem  [LEVELS];
    logic [BW-1:0]    budget_mem[LEVELS];
    logic [7:0]       task_mem  [LEVELS * QUEUE_DEPTH];
    logic [CNTW-1:0]  count_q;
    logic [HW-1:0]    head_q;
    logic [BW-1:0]    budget_q;
    logic [7:0]       task_q;

    // memory access controls
    logic [LW-1:0]    rd_lvl;
    logic [LW-1:0]    wr_lvl;
    logic [TAW-1:0]   task_rd_addr;
    logic [TAW-1:0]   task_wr_addr;
    logic             count_we, head_we, budget_we, task_we;
    logic [CNTW-1:0]  count_wd;
    logic [HW-1:0]    head_wd;
    logic [BW-1:0]    budget_wd;

    // decode of the latched request
    logic             lvl_ok;
    logic [LW-1:0]    lvl_idx;

    // enqueue datapath
    logic [CNTW-1:0]  count_eff;
    logic             queue_full;
    logic [CNTW:0]    tail_sum;
    logic [HW-1:0]    tail_pos;

    // charge datapath
    logic [BW-1:0]    bud_cur;
    logic [SW-1:0]    bud_ext, used_ext;
    logic [BW-1:0]    bud_new;

    // grant datapath
    logic [BW-1:0]    grant_bud;
    logic [HW-1:0]    head_inc;

    assign busy      = (state_reg != mlqs_pkg::S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign ready_vec = nonempty_reg & bnz_reg;

    assign lvl_ok  = (32'(req_reg.level) < 32'(LEVELS));
    assign lvl_idx = lvl_ok ? LW'(req_reg.level) : '0;

    // enqueue: position after the last entry, wrapping once
    assign count_eff  = nonempty_reg[lvl_idx] ? count_q : '0;
    assign queue_full = (count_eff == CNTW'(QUEUE_DEPTH));
    assign tail_sum   = (CNTW + 1)'(head_q) + (CNTW + 1)'(count_q);
    always_comb
    begin
        if (!nonempty_reg[lvl_idx])
        begin
            tail_pos = '0;
        end
        else if (tail_sum >= (CNTW + 1)'(QUEUE_DEPTH))
        begin
            tail_pos = HW'(tail_sum - (CNTW + 1)'(QUEUE_DEPTH));
        end
        else
        begin
            tail_pos = HW'(tail_sum);
        end
    end

    // charge: saturating subtract, unwritten budget reads as its reset value
    assign bud_cur  = bval_reg[lvl_idx] ? budget_q : (BW'(LEVELS) - BW'(lvl_idx));
    assign bud_ext  = SW'(bud_cur);
    assign used_ext = SW'(req_reg.used_slots);
    assign bud_new  = (bud_ext > used_ext) ? BW'(bud_ext - used_ext) : '0;

    // grant: budget of the found level and the advanced head
    assign grant_bud = bval_reg[scan_reg] ? budget_q : (BW'(LEVELS) - BW'(scan_reg));
    assign head_inc  = (head_q == HW'(QUEUE_DEPTH - 1)) ? '0 : HW'(head_q + 1'b1);

    // memory addresses: the scanned level stays selected through the fetch
    assign rd_lvl       = (state_reg == mlqs_pkg::S_SCAN ||
                           state_reg == mlqs_pkg::S_FETCH) ? scan_reg : lvl_idx;
    assign wr_lvl       = (state_reg == mlqs_pkg::S_GRANT) ? scan_reg : lvl_idx;
    assign task_rd_addr = TAW'(scan_reg) * TAW'(QUEUE_DEPTH) + TAW'(head_q);
    assign task_wr_addr = TAW'(lvl_idx) * TAW'(QUEUE_DEPTH) + TAW'(tail_pos);

    always_ff @(posedge clk)
    begin
        count_q  <= count_mem[rd_lvl];
        head_q   <= head_mem[rd_lvl];
        budget_q <= budget_mem[rd_lvl];
        task_q   <= task_mem[task_rd_addr];
        if (count_we)
        begin
            count_mem[wr_lvl] <= count_wd;
        end
        if (head_we)
        begin
            head_mem[wr_lvl] <= head_wd;
        end
        if (budget_we)
        begin
            budget_mem[wr_lvl] <= budget_wd;
        end
        if (task_we)
        begin
            task_mem[task_wr_addr] <= req_reg.task_id;
        end
    end

    // request latch, payload only
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg <= req;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mlqs_pkg::S_IDLE;
            scan_reg      <= '0;
            pass_reg      <= 1'b0;
            nonempty_reg  <= '0;
            bnz_reg       <= '1;
            bval_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_reg      <= scan_next;
            pass_reg      <= pass_next;
            nonempty_reg  <= nonempty_next;
            bnz_reg       <= bnz_next;
            bval_reg      <= bval_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        scan_next      = scan_reg;
        pass_next      = pass_reg;
        nonempty_next  = nonempty_reg;
        bnz_next       = bnz_reg;
        bval_next      = bval_reg;
        rsp_valid_next = 1'b0;
        rsp_next       = rsp_reg;
        count_we       = 1'b0;
        head_we        = 1'b0;
        budget_we      = 1'b0;
        task_we        = 1'b0;
        count_wd       = '0;
        head_wd        = '0;
        budget_wd      = '0;

        unique case (state_reg)
            mlqs_pkg::S_IDLE:
            begin
                if (start)
                begin
                    if (req.mode == mlqs_pkg::MODE_REQUEST)
                    begin
                        state_next = mlqs_pkg::S_SCAN;
                        scan_next  = '0;
                        pass_next  = 1'b0;
                    end
                    else
                    begin
                        state_next = mlqs_pkg::S_READ;
                    end
                end
            end

            // entry memories are read at the request level here
            mlqs_pkg::S_READ:
            begin
                state_next = mlqs_pkg::S_EXEC;
            end

            mlqs_pkg::S_EXEC:
            begin
                state_next     = mlqs_pkg::S_IDLE;
                rsp_valid_next = 1'b1;
                rsp_next       = '{status: mlqs_pkg::ST_DONE, out_task: '0,
                                   out_level: '0, out_budget: '0};
                case (req_reg.mode)
                    mlqs_pkg::MODE_ENQUEUE:
                    begin
                        if (!lvl_ok || queue_full)
                        begin
                            rsp_next.status = mlqs_pkg::ST_OVERFLOW;
                        end
                        else
                        begin
                            task_we  = 1'b1;
                            count_we = 1'b1;
                            count_wd = CNTW'(count_eff + 1'b1);
                            // an empty queue restarts at position zero
                            head_we  = !nonempty_reg[lvl_idx];
                            head_wd  = '0;
                            nonempty_next[lvl_idx] = 1'b1;
                        end
                    end
                    mlqs_pkg::MODE_CHARGE:
                    begin
                        if (lvl_ok)
                        begin
                            budget_we = 1'b1;
                            budget_wd = bud_new;
                            bval_next[lvl_idx] = 1'b1;
                            bnz_next[lvl_idx]  = (bud_new != '0);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            // one level per cycle, lowest index first
            mlqs_pkg::S_SCAN:
            begin
                if (ready_vec[scan_reg])
                begin
                    state_next = mlqs_pkg::S_FETCH;
                end
                else if (scan_reg == LW'(LEVELS - 1))
                begin
                    if (!pass_reg)
                    begin
                        // nothing ready: refill every budget and walk again
                        pass_next = 1'b1;
                        scan_next = '0;
                        bval_next = '0;
                        bnz_next  = '1;
                    end
                    else
                    begin
                        state_next     = mlqs_pkg::S_IDLE;
                        rsp_valid_next = 1'b1;
                        rsp_next       = '{status: mlqs_pkg::ST_EMPTY, out_task: '0,
                                           out_level: '0, out_budget: '0};
                    end
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end

            // head is known, task memory is read here
            mlqs_pkg::S_FETCH:
            begin
                state_next = mlqs_pkg::S_GRANT;
            end

            mlqs_pkg::S_GRANT:
            begin
                state_next     = mlqs_pkg::S_IDLE;
                rsp_valid_next = 1'b1;
                rsp_next       = '{status: mlqs_pkg::ST_GRANT, out_task: task_q,
                                   out_level: 3'(scan_reg), out_budget: 4'(grant_bud)};
                head_we  = 1'b1;
                head_wd  = head_inc;
                count_we = 1'b1;
                count_wd = CNTW'(count_q - 1'b1);
                if (count_q == CNTW'(1))
                begin
                    nonempty_next[scan_reg] = 1'b0;
                end
            end

            default:
            begin
                state_next = mlqs_pkg::S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // a result always comes with the sequencer back at rest
    a_rsp_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (state_reg == mlqs_pkg::S_IDLE))
        else $error("result shown while sequencer busy");

    // an accepted request keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    // the level being fetched is still ready
    a_fetch_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mlqs_pkg::S_FETCH) |->
            (nonempty_reg[scan_reg] && bnz_reg[scan_reg]))
        else $error("fetching a level that is not ready");

    // a grant step always ends in a granted result
    a_grant_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mlqs_pkg::S_GRANT) |=>
            (rsp_valid && (rsp.status == mlqs_pkg::ST_GRANT)))
        else $error("grant step without granted result");
`endif

endmodule
